// ===== hw/rtl/imuocs_pkg.sv =====
// ----------------------------------------------------------------------------
// imuocs_pkg
// shared types and constants of the imu offset calibrate and scale core
// ----------------------------------------------------------------------------
package imuocs_pkg;

	localparam int AXES       = 9;
	localparam int RAW_W      = 16;
	localparam int OUT_W      = 32;
	localparam int FRAC_W     = 8;              // fraction bits of the offset
	localparam int SUM_W      = 32;             // 65536 samples of 16 bit fit
	localparam int CNT_W      = 17;             // sample count up to 65536
	localparam int CFG_W      = 16;
	localparam int DIFF_W     = RAW_W + FRAC_W + 1;
	localparam int COEF_W     = 24;
	localparam int PROD_W     = 48;
	localparam int COEF_SHIFT = 24;
	localparam int DIV_W      = SUM_W + FRAC_W; // dividend magnitude bits
	localparam int REM_W      = CNT_W;
	localparam int QUO_W      = 25;             // quotient magnitude bits kept
	localparam int STEP_W     = $clog2(DIV_W + 2);

	localparam int AXIS_ACCEL_Z = 2;

	localparam logic [CFG_W-1:0] CAL_COUNT_RESET = 16'd200;

	localparam logic signed [COEF_W-1:0] COEF_ACCEL = 24'sd2573730;
	localparam logic signed [COEF_W-1:0] COEF_GYRO  = 24'sd4575276;
	localparam logic signed [COEF_W-1:0] COEF_MAG   = 24'sd523986;
	localparam logic signed [OUT_W-1:0]  GRAVITY_Q16 = 32'sd643432;

	typedef struct packed {
		logic signed [RAW_W-1:0] accel_x;
		logic signed [RAW_W-1:0] accel_y;
		logic signed [RAW_W-1:0] accel_z;
		logic signed [RAW_W-1:0] gyro_x;
		logic signed [RAW_W-1:0] gyro_y;
		logic signed [RAW_W-1:0] gyro_z;
		logic signed [RAW_W-1:0] mag_x;
		logic signed [RAW_W-1:0] mag_y;
		logic signed [RAW_W-1:0] mag_z;
	} sample_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] accel_x_ms2;
		logic signed [OUT_W-1:0] accel_y_ms2;
		logic signed [OUT_W-1:0] accel_z_ms2;
		logic signed [OUT_W-1:0] rate_x_rads;
		logic signed [OUT_W-1:0] rate_y_rads;
		logic signed [OUT_W-1:0] rate_z_rads;
		logic signed [OUT_W-1:0] field_x;
		logic signed [OUT_W-1:0] field_y;
		logic signed [OUT_W-1:0] field_z;
	} result_t;

	typedef struct packed {
		logic acc_en;
		logic div_load;
		logic div_step;
		logic div_done;
		logic pipe_en;
	} lane_ctrl_t;

	function automatic logic signed [COEF_W-1:0] axis_coef(input int axis);
		logic signed [COEF_W-1:0] c;
		if (axis < 3) begin
			c = COEF_ACCEL;
		end else if (axis < 6) begin
			c = COEF_GYRO;
		end else begin
			c = COEF_MAG;
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/imuocs_lane.sv =====
// ----------------------------------------------------------------------------
// imuocs_lane
// one axis: calibration sum, serial mean divider, offset removal and scaling
// ----------------------------------------------------------------------------
module imuocs_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  imuocs_pkg::lane_ctrl_t                ctrl,
	input  logic signed [imuocs_pkg::RAW_W-1:0]   raw,
	input  logic signed [imuocs_pkg::COEF_W-1:0]  coef,
	input  logic [imuocs_pkg::CNT_W-1:0]          divisor,
	output logic signed [imuocs_pkg::OUT_W-1:0]   res
);
	import imuocs_pkg::*;

	localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (COEF_SHIFT - 1);

	logic signed [SUM_W-1:0]  acc_q;     // running sum, then offset in q.8
	logic [DIV_W-1:0]         work_q;    // dividend shifting out, quotient in
	logic [REM_W-1:0]         rem_q;
	logic                     neg_q;
	logic [SUM_W-1:0]         acc_bits;
	logic [SUM_W-1:0]         sum_mag;
	logic [REM_W:0]           trial;
	logic [REM_W:0]           trial_sub;
	logic                     fits;
	logic [QUO_W-1:0]         quo_mag;
	logic [QUO_W-1:0]         quo_signed;
	logic signed [DIFF_W-1:0] raw_q8;
	logic signed [DIFF_W-1:0] diff_d;
	logic signed [DIFF_W-1:0] d_s1;
	logic signed [PROD_W:0]   prod;
	logic signed [PROD_W-1:0] p_s2;
	logic signed [PROD_W-1:0] p_round;

	always_comb begin
		acc_bits   = acc_q;
		sum_mag    = acc_bits[SUM_W-1] ? (~acc_bits + 1'b1) : acc_bits;
		trial      = {rem_q, work_q[DIV_W-1]};
		fits       = (trial >= {1'b0, divisor});
		trial_sub  = trial - {1'b0, divisor};
		quo_mag    = work_q[QUO_W-1:0];
		quo_signed = neg_q ? (~quo_mag + 1'b1) : quo_mag;
		raw_q8     = {raw[RAW_W-1], raw, {FRAC_W{1'b0}}};
		diff_d     = raw_q8 - acc_q[DIFF_W-1:0];
		prod       = d_s1 * coef;
		p_round    = p_s2 + HALF_LSB;
		res        = {{(OUT_W - (PROD_W - COEF_SHIFT)){p_round[PROD_W-1]}},
			p_round[PROD_W-1:COEF_SHIFT]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + {{(SUM_W - RAW_W){raw[RAW_W-1]}}, raw};
		end else if (ctrl.div_done) begin
			acc_q <= {{(SUM_W - QUO_W){quo_signed[QUO_W-1]}}, quo_signed};
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			work_q <= {sum_mag, {FRAC_W{1'b0}}};
			rem_q  <= '0;
			neg_q  <= acc_bits[SUM_W-1];
		end else if (ctrl.div_step) begin
			work_q <= {work_q[DIV_W-2:0], fits};
			rem_q  <= fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pipe_en) begin
			d_s1 <= diff_d;
			p_s2 <= prod[PROD_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/imuocs_ctrl.sv =====
// ----------------------------------------------------------------------------
// imuocs_ctrl
// calibration sequencer, divide step counter and pipeline flow control
// ----------------------------------------------------------------------------
module imuocs_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [imuocs_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  logic                             result_valid,
	input  logic                             result_stall,
	output imuocs_pkg::lane_ctrl_t           lane_ctrl,
	output logic [imuocs_pkg::CNT_W-1:0]     divisor,
	output logic                             pipe_valid
);
	import imuocs_pkg::*;

	localparam logic [1:0] ST_CALIB  = 2'd0;
	localparam logic [1:0] ST_DIVIDE = 2'd1;
	localparam logic [1:0] ST_RUN    = 2'd2;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W);
	localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(DIV_W + 1);

	logic [1:0]        state_q;
	logic [CFG_W-1:0]  cal_count_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] step_q;
	logic              v_s1_q;
	logic              v_s2_q;
	logic              pipe_en;
	logic              fire;
	logic [CNT_W-1:0]  cnt_next;
	logic              cal_done;

	always_comb begin
		pipe_en  = !result_valid || !result_stall;
		unique case (state_q)
			ST_CALIB:  sample_stall = 1'b0;
			ST_RUN:    sample_stall = !pipe_en;
			default:   sample_stall = 1'b1;
		endcase
		fire     = sample_valid && !sample_stall;
		cnt_next = cnt_q + 1'b1;
		cal_done = (cnt_next > {1'b0, cal_count_q});

		lane_ctrl.acc_en   = fire && (state_q == ST_CALIB);
		lane_ctrl.div_load = (state_q == ST_DIVIDE) && (step_q == '0);
		lane_ctrl.div_step = (state_q == ST_DIVIDE) && (step_q != '0) && (step_q <= STEP_LAST);
		lane_ctrl.div_done = (state_q == ST_DIVIDE) && (step_q == STEP_DONE);
		lane_ctrl.pipe_en  = pipe_en;
		divisor            = cnt_q;
		pipe_valid         = v_s2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_count_q <= CAL_COUNT_RESET;
		end else if (cfg_we) begin
			cal_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CALIB;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CALIB: begin
					if (fire) begin
						cnt_q <= cnt_next;
						if (cal_done) begin
							state_q <= ST_DIVIDE;
							step_q  <= '0;
						end
					end
				end
				ST_DIVIDE: begin
					if (step_q == STEP_DONE) begin
						state_q <= ST_RUN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_RUN: begin
				end
				default: begin
					state_q <= ST_CALIB;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else if (pipe_en) begin
			v_s1_q <= fire && (state_q == ST_RUN);
			v_s2_q <= v_s1_q;
		end
	end

	a_run_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> (state_q == ST_RUN))
		else $error("left run state after calibration");

	a_step_only_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != '0) |-> (state_q == ST_DIVIDE || state_q == ST_RUN))
		else $error("divide step counter moved outside divide");

	a_pipe_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q || v_s2_q) |-> (state_q == ST_RUN))
		else $error("beat in scaling pipeline before calibration ended");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (cnt_q != '0))
		else $error("mean divider started with zero sample count");

endmodule

// ===== hw/rtl/imuocs_merge.sv =====
// ----------------------------------------------------------------------------
// imuocs_merge
// gathers the nine lane results, adds gravity to accel z, output register
// ----------------------------------------------------------------------------
module imuocs_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pipe_en,
	input  logic                                 pipe_valid,
	input  logic signed [imuocs_pkg::OUT_W-1:0]  lane_res [imuocs_pkg::AXES],
	output logic                                 result_valid,
	output imuocs_pkg::result_t                  result
);
	import imuocs_pkg::*;

	logic    valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pipe_en) begin
			valid_q <= pipe_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			result_q.accel_x_ms2 <= lane_res[0];
			result_q.accel_y_ms2 <= lane_res[1];
			result_q.accel_z_ms2 <= lane_res[AXIS_ACCEL_Z] + GRAVITY_Q16;
			result_q.rate_x_rads <= lane_res[3];
			result_q.rate_y_rads <= lane_res[4];
			result_q.rate_z_rads <= lane_res[5];
			result_q.field_x     <= lane_res[6];
			result_q.field_y     <= lane_res[7];
			result_q.field_z     <= lane_res[8];
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// ===== hw/rtl/imu_offset_calibrate_and_scale_core.sv =====
// ----------------------------------------------------------------------------
// imu_offset_calibrate_and_scale_core
// nine-axis bias calibration by mean, then offset removal and scaling to q15.16
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                     payload
// sample    in         sample_valid / sample_stall   sample_t, nine raw 16 bit axes
// result    out        result_valid / result_stall   result_t, nine q15.16 values
// config    in         cfg_we                        cfg_wdata, calibration count
//
// calibration beats are taken one a cycle and give no result
// after the last calibration beat the nine lanes run a restoring divide,
//   one quotient bit a cycle, while the sample port stalls
// once calibrated a beat enters every cycle unless result_stall holds it; its result
//   passes through d register, multiplier register and the output register
// result_stall while result_valid freezes the whole scaling pipeline and, once calibrated, stalls the sample port
// reset clears sums, count and calibration state; no clearing pass is needed
//
module imu_offset_calibrate_and_scale_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [imuocs_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  imuocs_pkg::sample_t           sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output imuocs_pkg::result_t           result
);
	import imuocs_pkg::*;

	lane_ctrl_t              lane_ctrl;
	logic [CNT_W-1:0]        divisor;
	logic                    pipe_valid;
	logic signed [RAW_W-1:0] raw [AXES];
	logic signed [OUT_W-1:0] lane_res [AXES];

	// axis order of the lanes follows the field order of the beat
	always_comb begin
		raw[0] = sample.accel_x;
		raw[1] = sample.accel_y;
		raw[2] = sample.accel_z;
		raw[3] = sample.gyro_x;
		raw[4] = sample.gyro_y;
		raw[5] = sample.gyro_z;
		raw[6] = sample.mag_x;
		raw[7] = sample.mag_y;
		raw[8] = sample.mag_z;
	end

	// sequencer: calibration count, divide steps, pipeline valid bits
	imuocs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.lane_ctrl    (lane_ctrl),
		.divisor      (divisor),
		.pipe_valid   (pipe_valid)
	);

	// one lane per axis, each with its own accumulator, divider and multiplier
	for (genvar i = 0; i < AXES; i++) begin : g_lane
		imuocs_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (lane_ctrl),
			.raw     (raw[i]),
			.coef    (axis_coef(i)),
			.divisor (divisor),
			.res     (lane_res[i])
		);
	end

	// output register gathers the lanes into one result beat
	imuocs_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.pipe_en      (lane_ctrl.pipe_en),
		.pipe_valid   (pipe_valid),
		.lane_res     (lane_res),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== sim/tb_imu_offset_calibrate_and_scale_core.sv =====
// ----------------------------------------------------------------------------
// tb_imu_offset_calibrate_and_scale_core
// self-checking bench for the nine-axis mean calibration and scaling core:
// a bit-exact predictor follows every accepted sample beat, tracks the
// calibration sums and offsets, and checks each result beat field by field
// while the sender bursts and the receiver stalls at random
// ----------------------------------------------------------------------------
module tb_imu_offset_calibrate_and_scale_core;
	timeunit 1ns;
	timeprecision 1ps;

	import imuocs_pkg::*;

	class imu_scale_scoreboard;

		// q24 gains from q.8 counts to q.16
		localparam longint ACCEL_GAIN  = 2573730;
		localparam longint GYRO_GAIN   = 4575276;
		localparam longint MAG_GAIN    = 523986;
		localparam longint GRAVITY_FIX = 643432;
		localparam int     GAIN_SHIFT  = 24;

		longint      axis_acc [AXES];  // sum while calibrating, then offset in q.8
		int unsigned taken;
		bit          calibrated;
		int unsigned cal_count;
		result_t     pending_readings [$];
		string       field_name [AXES];
		int          fails;
		int          results_checked;
		int          cal_beats;
		int          scaled_beats;

		function new();
			foreach (axis_acc[i]) axis_acc[i] = 0;
			taken           = 0;
			calibrated      = 1'b0;
			cal_count       = CAL_COUNT_RESET;
			fails           = 0;
			results_checked = 0;
			cal_beats       = 0;
			scaled_beats    = 0;
			field_name = '{"accel_x_ms2", "accel_y_ms2", "accel_z_ms2",
				"rate_x_rads", "rate_y_rads", "rate_z_rads",
				"field_x", "field_y", "field_z"};
		endfunction

		function void report(string msg);
			fails++;
			if (fails <= 100) $display("mismatch: %s", msg);
		endfunction

		function void note_config(logic [CFG_W-1:0] value);
			cal_count = value;
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction

		function longint offset_whole(int axis);
			return axis_acc[axis] >>> FRAC_W;
		endfunction

		// advance the predicted state by one accepted sample beat
		function void take_sample(sample_t s);
			logic signed [RAW_W-1:0] raw;
			longint                  d;
			longint                  gain;
			longint                  scaled;
			longint                  count_div;
			result_t                 want;
			want = '0;
			if (!calibrated) begin
				cal_beats++;
				for (int i = 0; i < AXES; i++) begin
					raw = s[RAW_W*(AXES-1-i) +: RAW_W];
					axis_acc[i] += raw;
				end
				taken++;
				if (taken > cal_count) begin
					count_div = taken;
					foreach (axis_acc[i]) axis_acc[i] = (axis_acc[i] * 256) / count_div;
					taken      = 0;
					calibrated = 1'b1;
				end
			end else begin
				scaled_beats++;
				for (int i = 0; i < AXES; i++) begin
					raw  = s[RAW_W*(AXES-1-i) +: RAW_W];
					d    = longint'(raw) * 256 - axis_acc[i];
					gain = (i < 3) ? ACCEL_GAIN : (i < 6) ? GYRO_GAIN : MAG_GAIN;
					scaled = (d * gain + (longint'(1) <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
					if (i == AXIS_ACCEL_Z) scaled += GRAVITY_FIX;
					want[OUT_W*(AXES-1-i) +: OUT_W] = scaled[OUT_W-1:0];
				end
				pending_readings.push_back(want);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_readings.size() == 0) begin
				report("result beat with no scaled sample waiting");
			end else begin
				want = pending_readings.pop_front();
				results_checked++;
				for (int i = 0; i < AXES; i++) begin
					if (got[OUT_W*(AXES-1-i) +: OUT_W] !== want[OUT_W*(AXES-1-i) +: OUT_W]) begin
						report($sformatf("result %0d %s: got %0d want %0d", results_checked,
							field_name[i], $signed(got[OUT_W*(AXES-1-i) +: OUT_W]),
							$signed(want[OUT_W*(AXES-1-i) +: OUT_W])));
					end
				end
			end
		endfunction

	endclass

	// divide pass plus the 3 stage scaling pipe, with margin
	localparam int     SETTLE_CYCLES = 64;
	localparam int     DRAIN_LIMIT   = 20000;
	localparam longint RUN_LIMIT_NS  = 2_000_000;
	localparam int     PHASE_BEATS   = 300;

	localparam logic signed [RAW_W-1:0] RAW_MAX = 16'sh7FFF;
	localparam logic signed [RAW_W-1:0] RAW_MIN = 16'sh8000;

	localparam logic [CFG_W-1:0] CAL_COUNT_ZERO = '0;
	localparam logic [CFG_W-1:0] CAL_COUNT_ONE  = 16'd1;
	localparam logic [CFG_W-1:0] CAL_COUNT_MAX  = '1;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY, STALL_BLOCKS} stall_mode_e;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_we       = 1'b0;
	logic [CFG_W-1:0] cfg_wdata    = '0;
	logic             sample_valid = 1'b0;
	logic             sample_stall;
	sample_t          sample_beat  = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result_beat;

	imu_scale_scoreboard sb;
	stall_mode_e         stall_mode = STALL_NONE;
	int                  stall_left = 0;
	int                  burst_left = 0;
	bit                  gapless    = 1'b0;
	int                  cfg_writes = 0;

	imu_offset_calibrate_and_scale_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_beat)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// result side: check every accepted beat, then pick the stall for the next edge
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result_beat);
		end
		// the stall pattern switches between modes at random
		if (stall_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 4));
			stall_left = $urandom_range(16, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE:  result_stall <= 1'b0;
			STALL_LIGHT: result_stall <= ($urandom_range(0, 7) == 0);
			STALL_HALF:  result_stall <= $urandom_range(0, 1);
			STALL_HEAVY: result_stall <= ($urandom_range(0, 7) != 0);
			default:     result_stall <= ((stall_left % 24) < 16);  // long solid stalls
		endcase
	end

	// one sample beat, held until taken; bursts of random length, with gaps between unless gapless
	task automatic send_sample(input sample_t s);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if (!gapless && $urandom_range(0, 3) != 0) begin
				gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
			end
		end
		burst_left--;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_beat  <= s;
		do @(posedge clk); while (!(sample_valid && !sample_stall));
		sb.take_sample(s);
	endtask

	task automatic write_cal_count(input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.note_config(value);
		cfg_writes++;
	endtask

	// drop valid, let every expected result out, then allow for the divide pass
	task automatic settle();
		int guard;
		guard = 0;
		sample_valid <= 1'b0;
		while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic sample_t fill_axes(input logic signed [RAW_W-1:0] v);
		sample_t s;
		for (int i = 0; i < AXES; i++) s[RAW_W*i +: RAW_W] = v;
		return s;
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		for (int i = 0; i < AXES; i++) s[RAW_W*i +: RAW_W] = $urandom_range(0, 65535);
		return s;
	endfunction

	// each axis at one of the corner values
	function automatic sample_t edge_sample();
		sample_t s;
		for (int i = 0; i < AXES; i++) begin
			case ($urandom_range(0, 4))
				0:       s[RAW_W*i +: RAW_W] = RAW_MAX;
				1:       s[RAW_W*i +: RAW_W] = RAW_MIN;
				2:       s[RAW_W*i +: RAW_W] = '0;
				3:       s[RAW_W*i +: RAW_W] = '1;
				default: s[RAW_W*i +: RAW_W] = 16'sd1;
			endcase
		end
		return s;
	endfunction

	// raw values close to the learned offset: small differences, rounding edges
	function automatic sample_t near_offset_sample(input int spread);
		sample_t s;
		longint  v;
		for (int i = 0; i < AXES; i++) begin
			v = sb.offset_whole(i) + longint'($urandom_range(0, 2 * spread)) - spread;
			if (v > RAW_MAX) begin
				v = RAW_MAX;
			end else if (v < RAW_MIN) begin
				v = RAW_MIN;
			end
			s[RAW_W*(AXES-1-i) +: RAW_W] = v[RAW_W-1:0];
		end
		return s;
	endfunction

	function automatic sample_t scaled_stimulus();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return random_sample();
		if (pick < 75) return edge_sample();
		return near_offset_sample(4);
	endfunction

	initial begin
		#(RUN_LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] phase_count [4];
		int               extra;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// one short calibration per run, its length set by mid-run count changes
		gapless = ($urandom_range(0, 1) == 0);
		write_cal_count(CAL_COUNT_MAX);

		// rails and bit patterns into the sums
		send_sample(fill_axes(RAW_MAX));
		send_sample(fill_axes(RAW_MIN));
		send_sample(fill_axes('0));
		send_sample(fill_axes('1));
		send_sample(fill_axes(16'sh5555));
		send_sample(fill_axes(16'shAAAA));

		repeat ($urandom_range(10, 120)) send_sample(random_sample());
		// raise the count mid-calibration, stay at or below it
		settle();
		extra = $urandom_range(3, 40);
		write_cal_count(CFG_W'(sb.taken + extra));
		repeat ($urandom_range(1, extra)) send_sample(random_sample());
		// count of zero, already passed: the next beat ends calibration
		settle();
		write_cal_count(CAL_COUNT_ZERO);
		send_sample(random_sample());

		// first beats after calibration, the first one waits out the divide
		gapless = 1'b0;
		send_sample(near_offset_sample(0));
		send_sample(fill_axes(RAW_MAX));
		send_sample(fill_axes(RAW_MIN));
		send_sample(fill_axes('0));
		send_sample(fill_axes(16'sd1));
		send_sample(fill_axes('1));
		send_sample(edge_sample());
		send_sample(edge_sample());
		send_sample(near_offset_sample(1));
		send_sample(near_offset_sample(1));

		// register writes once calibrated are stored but change nothing
		phase_count[0] = CAL_COUNT_ONE;
		phase_count[1] = CFG_W'($urandom_range(2, 65534));
		phase_count[2] = CAL_COUNT_MAX;
		phase_count[3] = CAL_COUNT_ZERO;
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			write_cal_count(phase_count[ph]);
			gapless = ($urandom_range(0, 3) == 0);
			repeat (PHASE_BEATS) send_sample(scaled_stimulus());
		end

		settle();
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		end

		$display("run: calibration of %0d beats with mid-run count changes, then %0d scaled beats",
			sb.cal_beats, sb.scaled_beats);
		$display("run: %0d results checked on all nine fields, %0d register writes",
			sb.results_checked, cfg_writes);
		if (sb.fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
